/* src/bar_pkg.sv */
// Package for the body-to-NED acceleration rotation block.
// Holds fixed-point constants and the item type passed from front to back.
`default_nettype none
package bar_pkg;
    localparam int unsigned IN_W  = 16;
    localparam int unsigned OUT_W = 19;
    localparam int unsigned QW    = 32;   // signed Q30 trig and matrix entries
    localparam logic [QW-1:0] Q30_ONE = 32'h4000_0000;
    localparam logic [23:0] G_Q20 = 24'd10283018;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sh3FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 19'sh40000;
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598669;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026995;
    localparam logic [31:0] SIN_C9 = 32'd172272;

    // One accepted sample, queued between the front and the back.
    typedef struct packed {
        logic signed [IN_W-1:0] ax;
        logic signed [IN_W-1:0] ay;
        logic signed [IN_W-1:0] az;
        logic [IN_W-1:0] roll;
        logic [IN_W-1:0] pitch;
        logic [IN_W-1:0] yaw;
    } item_t;

    // Round a signed product down by 30 bits, half away from zero.
    function automatic logic signed [QW-1:0] rnd30(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + 64'(1) * (64'd1 << 29)) >> 30;
        return v[63] ? QW'(-r) : QW'(r);
    endfunction
endpackage
`default_nettype wire

/* src/bar_fifo.sv */
// Front end: accepts samples into a short queue that decouples input from pipeline.
// Depends on bar_pkg.
`default_nettype none
module bar_fifo import bar_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        out_valid,
    input  wire         out_ready,
    output item_t       out_item
);
    item_t       mem_reg [4];
    logic [1:0]  wr_reg, rd_reg;
    logic [2:0]  cnt_reg;
    logic        push, pop;

    assign in_ready  = (cnt_reg != 3'd4);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_item  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end
endmodule
`default_nettype wire

/* src/bar_sine.sv */
// Registered sine/cosine pipeline for one binary angle, six stages.
// Depends on bar_pkg; result in signed Q30.
`default_nettype none
module bar_sine import bar_pkg::*; (
    input  wire                   aclk,
    input  wire                   en,
    input  wire  [IN_W-1:0]       angle,
    output logic signed [QW-1:0]  sin_q,
    output logic signed [QW-1:0]  cos_q
);
    // Quarter index and folded phase for sine (s) and cosine (c).
    logic [15:0] ph_c;
    logic [14:0] us, uc;
    assign ph_c = angle + 16'd16384;
    assign us = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    assign uc = ph_c[14] ? 15'(15'd16384 - {1'b0, ph_c[13:0]}) : {1'b0, ph_c[13:0]};

    // Stage 1: z and z^2 (z = u<<16, so z*z>>30 = u*u<<2).
    logic [30:0] zs_reg, zc_reg;
    logic [31:0] z2s_reg, z2c_reg;
    logic        ns1_reg, nc1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            zs_reg  <= {us, 16'd0};
            zc_reg  <= {uc, 16'd0};
            z2s_reg <= {30'(us) * 30'(us), 2'b00};
            z2c_reg <= {30'(uc) * 30'(uc), 2'b00};
            ns1_reg <= angle[15];
            nc1_reg <= ph_c[15];
        end
    end

    // Horner steps, one multiply per stage.
    logic [31:0] c_arr [4];
    assign c_arr[0] = SIN_C7;
    assign c_arr[1] = SIN_C5;
    assign c_arr[2] = SIN_C3;
    assign c_arr[3] = SIN_C1;

    logic [30:0] zs_p [5], zc_p [5];
    logic [31:0] z2s_p [5], z2c_p [5], ts_p [5], tc_p [5];
    logic        ns_p [5], nc_p [5];
    assign zs_p[0] = zs_reg;  assign zc_p[0] = zc_reg;
    assign z2s_p[0] = z2s_reg; assign z2c_p[0] = z2c_reg;
    assign ts_p[0] = SIN_C9;  assign tc_p[0] = SIN_C9;
    assign ns_p[0] = ns1_reg; assign nc_p[0] = nc1_reg;

    genvar k;
    generate
        for (k = 0; k < 4; k++) begin : g_horner
            logic [30:0] zs_r, zc_r;
            logic [31:0] z2s_r, z2c_r, ts_r, tc_r;
            logic        ns_r, nc_r;
            always_ff @(posedge aclk) begin
                if (en) begin
                    zs_r <= zs_p[k]; zc_r <= zc_p[k];
                    z2s_r <= z2s_p[k]; z2c_r <= z2c_p[k];
                    ns_r <= ns_p[k]; nc_r <= nc_p[k];
                    ts_r <= c_arr[k] - 32'((64'(z2s_p[k]) * 64'(ts_p[k])) >> 30);
                    tc_r <= c_arr[k] - 32'((64'(z2c_p[k]) * 64'(tc_p[k])) >> 30);
                end
            end
            assign zs_p[k+1] = zs_r; assign zc_p[k+1] = zc_r;
            assign z2s_p[k+1] = z2s_r; assign z2c_p[k+1] = z2c_r;
            assign ts_p[k+1] = ts_r; assign tc_p[k+1] = tc_r;
            assign ns_p[k+1] = ns_r; assign nc_p[k+1] = nc_r;
        end
    endgenerate

    // Final multiply by z, clamp to one, apply sign of the half turn.
    logic [63:0] fs, fc;
    logic [31:0] ms, mc;
    assign fs = (64'(zs_p[4]) * 64'(ts_p[4])) >> 30;
    assign fc = (64'(zc_p[4]) * 64'(tc_p[4])) >> 30;
    assign ms = (fs > 64'(Q30_ONE)) ? Q30_ONE : fs[31:0];
    assign mc = (fc > 64'(Q30_ONE)) ? Q30_ONE : fc[31:0];
    always_ff @(posedge aclk) begin
        if (en) begin
            sin_q <= ns_p[4] ? -$signed(ms) : $signed(ms);
            cos_q <= nc_p[4] ? -$signed(mc) : $signed(mc);
        end
    end
endmodule
`default_nettype wire

/* src/bar_rotate.sv */
// Back end: trig, matrix, dot products, scaling and saturation in a stall-able pipeline.
// Depends on bar_pkg and bar_sine.
`default_nettype none
module bar_rotate import bar_pkg::*; (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            in_valid,
    output logic           in_ready,
    input  item_t          in_item,
    output logic           out_valid,
    input  wire            out_ready,
    output logic signed [OUT_W-1:0] north,
    output logic signed [OUT_W-1:0] east,
    output logic signed [OUT_W-1:0] down
);
    localparam int unsigned DEPTH = 11;

    // Whole pipeline advances together; output register holds when stalled.
    logic en;
    logic [DEPTH-1:0] vld_reg;
    assign en = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    // Trig units: six stages.
    logic signed [QW-1:0] sr, cr, sp, cp, sy, cy;
    bar_sine u_roll  (.aclk(aclk), .en(en), .angle(in_item.roll),  .sin_q(sr), .cos_q(cr));
    bar_sine u_pitch (.aclk(aclk), .en(en), .angle(in_item.pitch), .sin_q(sp), .cos_q(cp));
    bar_sine u_yaw   (.aclk(aclk), .en(en), .angle(in_item.yaw),   .sin_q(sy), .cos_q(cy));

    // Sample delay line matching the trig latency.
    logic signed [IN_W-1:0] ax_d [6], ay_d [6], az_d [6];
    always_ff @(posedge aclk) begin
        if (en) begin
            ax_d[0] <= in_item.ax; ay_d[0] <= in_item.ay; az_d[0] <= in_item.az;
            for (int i = 1; i < 6; i++) begin
                ax_d[i] <= ax_d[i-1]; ay_d[i] <= ay_d[i-1]; az_d[i] <= az_d[i-1];
            end
        end
    end

    // Stage A: first products.
    logic signed [QW-1:0] cysp_r, sysp_r, m00_r, m10_r, m21_r, m22_r, m20_r;
    logic signed [QW-1:0] sycr_r, sysr_r, cycr_r, cysr_r, sr_a, cr_a;
    logic signed [IN_W-1:0] axa, aya, aza;
    always_ff @(posedge aclk) begin
        if (en) begin
            cysp_r <= rnd30(64'(cy) * 64'(sp));
            sysp_r <= rnd30(64'(sy) * 64'(sp));
            m00_r <= rnd30(64'(cy) * 64'(cp));
            m10_r <= rnd30(64'(sy) * 64'(cp));
            m21_r <= rnd30(64'(cp) * 64'(sr));
            m22_r <= rnd30(64'(cp) * 64'(cr));
            m20_r <= -sp;
            sycr_r <= rnd30(64'(sy) * 64'(cr));
            sysr_r <= rnd30(64'(sy) * 64'(sr));
            cycr_r <= rnd30(64'(cy) * 64'(cr));
            cysr_r <= rnd30(64'(cy) * 64'(sr));
            sr_a <= sr; cr_a <= cr;
            axa <= ax_d[5]; aya <= ay_d[5]; aza <= az_d[5];
        end
    end

    // Stage B: remaining matrix entries.
    logic signed [QW-1:0] m [9];
    logic signed [IN_W-1:0] axb, ayb, azb;
    always_ff @(posedge aclk) begin
        if (en) begin
            m[0] <= m00_r;
            m[1] <= rnd30(64'(cysp_r) * 64'(sr_a)) - sycr_r;
            m[2] <= rnd30(64'(cysp_r) * 64'(cr_a)) + sysr_r;
            m[3] <= m10_r;
            m[4] <= rnd30(64'(sysp_r) * 64'(sr_a)) + cycr_r;
            m[5] <= rnd30(64'(sysp_r) * 64'(cr_a)) - cysr_r;
            m[6] <= m20_r; m[7] <= m21_r; m[8] <= m22_r;
            axb <= axa; ayb <= aya; azb <= aza;
        end
    end

    // Stage C: dot products, 2^-42 g, then round by 16 bits.
    function automatic logic signed [35:0] rnd16(input logic signed [49:0] v);
        logic [49:0] a;
        a = v[49] ? 50'(-v) : 50'(v);
        a = (a + 50'd32768) >> 16;
        return v[49] ? 36'(-a) : 36'(a);
    endfunction

    logic signed [35:0] dot_r [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dot_r[i] <= rnd16(50'(m[3*i]) * 50'(axb) + 50'(m[3*i+1]) * 50'(ayb)
                                  + 50'(m[3*i+2]) * 50'(azb));
            end
        end
    end

    // Stage D: scale by G, add gravity on down.
    logic signed [61:0] sc_r [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sc_r[i] <= 62'(dot_r[i]) * $signed({38'd0, G_Q20})
                         + ((i == 2) ? $signed({12'd0, G_Q20, 26'd0}) : 62'sd0);
            end
        end
    end

    // Stage E: round by 36 bits and saturate into the output register.
    function automatic logic signed [OUT_W-1:0] fin(input logic signed [61:0] v);
        logic [61:0] a;
        logic signed [26:0] r;
        a = v[61] ? 62'(-v) : 62'(v);
        a = (a + (62'd1 << 35)) >> 36;
        r = v[61] ? 27'(-a) : 27'(a);
        if (r > 27'(OUT_MAX)) return OUT_MAX;
        if (r < 27'(OUT_MIN)) return OUT_MIN;
        return r[OUT_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            north <= fin(sc_r[0]);
            east  <= fin(sc_r[1]);
            down  <= fin(sc_r[2]);
        end
    end
endmodule
`default_nettype wire

/* src/body_accel_to_ned_rotation_top.sv */
// Top level of the body-to-NED acceleration rotation block.
// Depends on bar_pkg, bar_fifo and bar_rotate.
//
//  Channel | Ports                                        | Direction
//  input   | s_valid s_ready s_accel_* s_*_angle          | in
//  result  | m_valid m_ready m_accel_north/east/down      | out
//
// One sample per cycle while results are taken; from queue head to result the
// delay is set by the six-stage sine pipeline and the matrix and scaling stages,
// and the queue's storage register sits ahead of them from the input beat.
// A four-entry queue sits in front; the back pipeline stalls as a whole
// when its output register is full and not taken.
// Reset (aresetn, synchronous) clears the queue and pipeline valid bits.
`default_nettype none
module body_accel_to_ned_rotation_top import bar_pkg::*; (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire  signed [IN_W-1:0]    s_accel_x,
    input  wire  signed [IN_W-1:0]    s_accel_y,
    input  wire  signed [IN_W-1:0]    s_accel_z,
    input  wire  signed [IN_W-1:0]    s_roll_angle,
    input  wire  signed [IN_W-1:0]    s_pitch_angle,
    input  wire  signed [IN_W-1:0]    s_yaw_angle,
    output logic                      m_valid,
    input  wire                       m_ready,
    output logic signed [OUT_W-1:0]   m_accel_north,
    output logic signed [OUT_W-1:0]   m_accel_east,
    output logic signed [OUT_W-1:0]   m_accel_down
);
    item_t in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item.ax = s_accel_x;
    assign in_item.ay = s_accel_y;
    assign in_item.az = s_accel_z;
    assign in_item.roll = s_roll_angle;
    assign in_item.pitch = s_pitch_angle;
    assign in_item.yaw = s_yaw_angle;

    bar_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_item(in_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    bar_rotate u_rot (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_valid), .out_ready(m_ready),
        .north(m_accel_north), .east(m_accel_east), .down(m_accel_down)
    );
endmodule
`default_nettype wire
